@@ hw/rtl/tga_pkg.sv @@
// Shared types and constants for the Targa run-length pixel decoder.
`timescale 1ns / 1ps

package tga_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_PIXEL_SIZE      = 2'd0;
  localparam logic [1:0] CFG_GRAYSCALE_MODE  = 2'd1;
  localparam logic [1:0] CFG_COMPRESSED_MODE = 2'd2;
  localparam logic [1:0] CFG_IMAGE_PIXELS    = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int PIX_CNT_W  = 31;

  // Reset values of the configuration registers
  localparam logic [2:0]           BPP_RST        = 3'd4;
  localparam logic                 GRAY_RST       = 1'b0;
  localparam logic                 COMP_RST       = 1'b1;
  localparam logic [PIX_CNT_W-1:0] IMAGE_PIX_RST  = 31'd16;

  // Packet header fields
  localparam logic [7:0] COUNT_MASK = 8'h7f;
  localparam int         RUN_FLAG_BIT = 7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic [2:0]           pixel_size;
    logic                 grayscale_mode;
    logic                 compressed_mode;
    logic [PIX_CNT_W-1:0] image_pixels;
  } cfg_t;

endpackage

@@ hw/rtl/tga_rle_pixel_decoder_top.sv @@
// Targa run-length pixel decoder: top level with input and result registers.
`timescale 1ns / 1ps

// Takes the image data of a Targa file one byte per transfer, after the file
// header, and returns unpacked pixels with a repeat count. One byte is taken
// every clock cycle as long as results are taken; a byte passes through an
// input register and then, once the result register is free, into the result
// register. The decode state is updated as the byte moves between those two
// registers, which sets the rate of one byte per cycle. Configuration
// writes take effect from the next byte and are meant for idle periods.
module tga_rle_pixel_decoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tga_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tga_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [tga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tga_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tga_pkg::*;

  cfg_t      cfg;
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  tga_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  tga_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_valid_r & advance),
    .item      (in_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register is free when empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // Hold input and result registers; move on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
        in_item_r  <= in_item;
      end
      if (advance) begin
        out_valid_r <= in_valid_r & res_valid;
        out_item_r  <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ hw/rtl/tga_cfg.sv @@
// Configuration register file of the Targa pixel decoder.
`timescale 1ns / 1ps

module tga_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tga_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tga_pkg::cfg_t                    cfg_o
);
  import tga_pkg::*;

  cfg_t cfg_r;

  // Write one register per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_size      <= BPP_RST;
      cfg_r.grayscale_mode  <= GRAY_RST;
      cfg_r.compressed_mode <= COMP_RST;
      cfg_r.image_pixels    <= IMAGE_PIX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_SIZE:      cfg_r.pixel_size      <= cfg_wdata[2:0];
        CFG_GRAYSCALE_MODE:  cfg_r.grayscale_mode  <= cfg_wdata[0];
        CFG_COMPRESSED_MODE: cfg_r.compressed_mode <= cfg_wdata[0];
        CFG_IMAGE_PIXELS:    cfg_r.image_pixels    <= cfg_wdata[PIX_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ hw/rtl/tga_core.sv @@
// Decode state and per-byte decode logic: packet parse, pixel gather and unpack.
`timescale 1ns / 1ps

module tga_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tga_pkg::in_item_t   item,
  input  tga_pkg::cfg_t       cfg,
  output logic                res_valid,
  output tga_pkg::out_item_t  res
);
  import tga_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_RAW    = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  phase_t               phase_r, phase_nxt, cur_phase;
  logic [7:0]           left_r, left_nxt, cur_left;
  logic [1:0]           pos_r, pos_nxt, cur_pos;
  logic [23:0]          pbytes_r, pbytes_nxt, cur_pbytes;
  logic [PIX_CNT_W-1:0] done_r, done_nxt, cur_done;

  logic [1:0]           bpp_m1;
  logic                 pix_complete;
  logic [7:0]           p0, p1, p2, p3;
  logic [23:0]          gather_pbytes;
  logic [31:0]          pix;
  logic [7:0]           b;
  logic [7:0]           size;
  logic [PIX_CNT_W:0]   total;
  logic [PIX_CNT_W-1:0] done_inc;
  logic [7:0]           left_dec;
  logic                 reached;

  assign b = item.data_byte;

  // Restart clears the state seen by this byte
  always_comb begin
    if (item.restart) begin
      cur_phase  = PH_HEADER;
      cur_left   = '0;
      cur_pos    = '0;
      cur_pbytes = '0;
      cur_done   = '0;
    end else begin
      cur_phase  = phase_r;
      cur_left   = left_r;
      cur_pos    = pos_r;
      cur_pbytes = pbytes_r;
      cur_done   = done_r;
    end
  end

  // Clamp pixel size to 1..4, held as size minus one
  always_comb begin
    unique case (cfg.pixel_size)
      3'd0, 3'd1: bpp_m1 = 2'd0;
      3'd2:       bpp_m1 = 2'd1;
      3'd3:       bpp_m1 = 2'd2;
      default:    bpp_m1 = 2'd3;
    endcase
  end

  // Gather the byte into the pixel being built
  always_comb begin
    pix_complete = (cur_pos >= bpp_m1);
    p0 = cur_pbytes[7:0];
    p1 = cur_pbytes[15:8];
    p2 = cur_pbytes[23:16];
    p3 = 8'd0;
    unique case (cur_pos)
      2'd0:    p0 = b;
      2'd1:    p1 = b;
      2'd2:    p2 = b;
      default: p3 = b;
    endcase
    gather_pbytes = {p2, p1, p0};
  end

  // Unpack BGR(A) to RGB(A), or pass one- or two-byte gray through; other formats give zero
  always_comb begin
    pix = '0;
    if (cfg.grayscale_mode) begin
      if (bpp_m1 == 2'd0)      pix = {24'd0, p0};
      else if (bpp_m1 == 2'd1) pix = {16'd0, p1, p0};
    end else begin
      unique case (bpp_m1)
        2'd1:    pix = {16'd0, p1[6:0], p1[7], p1[6:0], p0[7]};
        2'd2:    pix = {8'd0, p0, p1, p2};
        2'd3:    pix = {p3, p0, p1, p2};
        default: pix = '0;
      endcase
    end
  end

  assign size     = 8'd1 + (b & COUNT_MASK);
  assign total    = {1'b0, cur_done} + {{(PIX_CNT_W + 1 - 8){1'b0}}, size};
  assign done_inc = cur_done + {{(PIX_CNT_W - 1){1'b0}}, 1'b1};
  assign left_dec = (cur_left == 8'd0) ? 8'd0 : cur_left - 8'd1;
  assign reached  = (cur_done >= cfg.image_pixels);

  // Next state and result for this byte
  always_comb begin
    phase_nxt  = cur_phase;
    left_nxt   = cur_left;
    pos_nxt    = cur_pos;
    pbytes_nxt = cur_pbytes;
    done_nxt   = cur_done;
    res_valid  = 1'b0;
    res        = '0;

    if (cur_phase != PH_STOP) begin
      if (!cfg.compressed_mode || cur_phase != PH_HEADER) begin
        // Pixel byte: advance the gather
        if (pix_complete) begin
          pos_nxt    = '0;
          pbytes_nxt = '0;
        end else begin
          pos_nxt    = cur_pos + 2'd1;
          pbytes_nxt = gather_pbytes;
        end
      end

      if (!cfg.compressed_mode) begin
        if (pix_complete) begin
          done_nxt         = done_inc;
          res_valid        = 1'b1;
          res.pixel_value  = pix;
          res.repeat_count = 8'd1;
          if (done_inc >= cfg.image_pixels) begin
            phase_nxt      = PH_STOP;
            res.image_done = 1'b1;
          end
        end
      end else begin
        unique case (cur_phase)
          PH_HEADER: begin
            pos_nxt    = '0;
            pbytes_nxt = '0;
            if (total > {1'b0, cfg.image_pixels}) begin
              phase_nxt = PH_STOP;
              res_valid = 1'b1;
              res.error = 1'b1;
            end else begin
              done_nxt  = total[PIX_CNT_W-1:0];
              left_nxt  = size;
              phase_nxt = b[RUN_FLAG_BIT] ? PH_RUN : PH_RAW;
            end
          end
          PH_RUN: begin
            if (pix_complete) begin
              res_valid        = 1'b1;
              res.pixel_value  = pix;
              res.repeat_count = cur_left;
              res.image_done   = reached;
              left_nxt         = '0;
              phase_nxt        = reached ? PH_STOP : PH_HEADER;
            end
          end
          PH_RAW: begin
            if (pix_complete) begin
              res_valid        = 1'b1;
              res.pixel_value  = pix;
              res.repeat_count = 8'd1;
              left_nxt         = left_dec;
              if (left_dec == 8'd0) begin
                res.image_done = reached;
                phase_nxt      = reached ? PH_STOP : PH_HEADER;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Hold decode state; advance on each byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      left_r   <= '0;
      pos_r    <= '0;
      pbytes_r <= '0;
      done_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      pbytes_r <= pbytes_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Targa run-length pixel decoder.
`timescale 1ns / 1ps

module tb;
  import tga_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BYTES = 1300;

  typedef enum logic [1:0] {DEC_HEADER, DEC_RUN, DEC_RAW, DEC_STOP} dec_phase_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tga_rle_pixel_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the decoder registers
  logic [2:0]           m_bpp   = BPP_RST;
  logic                 m_gray  = GRAY_RST;
  logic                 m_comp  = COMP_RST;
  logic [PIX_CNT_W-1:0] m_total = IMAGE_PIX_RST;

  // Shadow copy of the decode state
  dec_phase_t           m_phase = DEC_HEADER;
  logic [7:0]           m_left  = '0;
  logic [1:0]           m_pos   = '0;
  logic [23:0]          m_acc   = '0;
  logic [PIX_CNT_W-1:0] m_seen  = '0;

  out_item_t want_pixels[$];
  out_item_t oldest;
  int        errors     = 0;
  int        cycles     = 0;
  int        live_bytes = 0;
  int        stall_wait = 0;
  bit        no_idle    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel decode prediction
  // ---------------------------------------------------------------------------

  function automatic logic [2:0] eff_bpp();
    if (m_bpp == 3'd0) return 3'd1;
    if (m_bpp > 3'd4) return 3'd4;
    return m_bpp;
  endfunction

  function automatic logic [31:0] unpack_pixel(input logic [7:0] p0, p1, p2, p3,
                                               input logic [2:0] bpp);
    logic [7:0] o0;
    logic [7:0] o1;
    if (m_gray) begin
      if (bpp == 3'd1) return {24'd0, p0};
      if (bpp == 3'd2) return {16'd0, p1, p0};
      return '0;
    end
    // 16-bit truecolor keeps its odd bit shuffle
    o0 = {p1[6:0], p0[7]};
    o1 = {p1[6:0], p1[7]};
    case (bpp)
      3'd2: return {16'd0, o1, o0};
      3'd3: return {8'd0, p0, p1, p2};
      3'd4: return {p3, p0, p1, p2};
      default: return '0;
    endcase
  endfunction

  // Collect one source byte; return 1 with the unpacked pixel once complete
  function automatic bit gather_byte(input logic [7:0] b, output logic [31:0] pix);
    logic [2:0] bpp;
    logic [7:0] p [4];
    bpp = eff_bpp();
    pix = '0;
    if ({1'b0, m_pos} + 3'd1 >= bpp) begin
      p[0] = m_acc[7:0];
      p[1] = m_acc[15:8];
      p[2] = m_acc[23:16];
      p[3] = 8'd0;
      p[m_pos] = b;
      pix = unpack_pixel(p[0], p[1], p[2], p[3], bpp);
      m_pos = '0;
      m_acc = '0;
      return 1'b1;
    end
    m_acc[8*m_pos +: 8] = m_acc[8*m_pos +: 8] | b;
    m_pos = m_pos + 2'd1;
    return 1'b0;
  endfunction

  // Advance the shadow decoder by one byte and queue any pixel it yields
  function automatic void decode_byte(input in_item_t it);
    logic [31:0] pix;
    logic [31:0] reach;
    out_item_t   res;
    if (it.restart) begin
      m_phase = DEC_HEADER;
      m_left  = '0;
      m_pos   = '0;
      m_acc   = '0;
      m_seen  = '0;
    end
    if (m_phase == DEC_STOP) return;
    live_bytes++;
    res = '0;

    // Plain pixel stream
    if (!m_comp) begin
      if (!gather_byte(it.data_byte, pix)) return;
      m_seen = m_seen + 1'b1;
      res.pixel_value  = pix;
      res.repeat_count = 8'd1;
      if (m_seen >= m_total) begin
        m_phase = DEC_STOP;
        res.image_done = 1'b1;
      end
      want_pixels.push_back(res);
      return;
    end

    // Packet header: announce the count, or flag an overrun
    if (m_phase == DEC_HEADER) begin
      reach = {1'b0, m_seen} + 32'(it.data_byte & COUNT_MASK) + 32'd1;
      m_pos = '0;
      m_acc = '0;
      if (reach > {1'b0, m_total}) begin
        m_phase   = DEC_STOP;
        res.error = 1'b1;
        want_pixels.push_back(res);
        return;
      end
      m_seen  = reach[PIX_CNT_W-1:0];
      m_left  = 8'(it.data_byte & COUNT_MASK) + 8'd1;
      m_phase = it.data_byte[RUN_FLAG_BIT] ? DEC_RUN : DEC_RAW;
      return;
    end

    if (!gather_byte(it.data_byte, pix)) return;
    res.pixel_value = pix;
    if (m_phase == DEC_RUN) begin
      res.repeat_count = m_left;
      res.image_done   = (m_seen >= m_total);
      m_left  = '0;
      m_phase = res.image_done ? DEC_STOP : DEC_HEADER;
    end else begin
      res.repeat_count = 8'd1;
      if (m_left != 8'd0) m_left = m_left - 8'd1;
      if (m_left == 8'd0) begin
        res.image_done = (m_seen >= m_total);
        m_phase = res.image_done ? DEC_STOP : DEC_HEADER;
      end
    end
    want_pixels.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    errors++;
    $display("mismatch %s: got %0h, wanted %0h, cycle %0d", what, got, wanted, cycles);
  endtask

  // Compare each result transfer with the oldest predicted pixel
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (want_pixels.size() == 0) begin
        report_mismatch("unexpected result", out_item.pixel_value, 32'd0);
      end else begin
        oldest = want_pixels.pop_front();
        if (out_item.pixel_value !== oldest.pixel_value)
          report_mismatch("pixel_value", out_item.pixel_value, oldest.pixel_value);
        if (out_item.repeat_count !== oldest.repeat_count)
          report_mismatch("repeat_count", 32'(out_item.repeat_count),
                          32'(oldest.repeat_count));
        if (out_item.image_done !== oldest.image_done)
          report_mismatch("image_done", 32'(out_item.image_done), 32'(oldest.image_done));
        if (out_item.error !== oldest.error)
          report_mismatch("error", 32'(out_item.error), 32'(oldest.error));
      end
      stall_wait = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  // Hold stall for the drawn number of cycles before the next result
  always @(negedge clk) begin
    if (stall_wait > 0) begin
      out_stall <= 1'b1;
      stall_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) @(posedge clk);
    $display("tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drive helpers
  // ---------------------------------------------------------------------------

  // Send one byte after a random gap; predict at the transfer
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_valid <= 1'b0;
      in_item  <= '{data_byte: 8'($urandom), restart: 1'($urandom)};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, restart: rs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(in_item);
    @(negedge clk);
  endtask

  // Drop valid and let every predicted pixel come out, plus the pipe depth
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (want_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all four registers, one per cycle
  task automatic set_config(input logic [2:0] bpp, input logic gray, input logic comp,
                            input logic [PIX_CNT_W-1:0] total);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PIXEL_SIZE;
    cfg_wdata <= CFG_DATA_W'(bpp);
    @(negedge clk);
    cfg_index <= CFG_GRAYSCALE_MODE;
    cfg_wdata <= CFG_DATA_W'(gray);
    @(negedge clk);
    cfg_index <= CFG_COMPRESSED_MODE;
    cfg_wdata <= CFG_DATA_W'(comp);
    @(negedge clk);
    cfg_index <= CFG_IMAGE_PIXELS;
    cfg_wdata <= total;
    @(negedge clk);
    cfg_we  <= 1'b0;
    m_bpp   = bpp;
    m_gray  = gray;
    m_comp  = comp;
    m_total = total;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one image: mostly well-formed packets or pixels, with a little noise
  task automatic random_image(input bit fresh);
    int left_px;
    int cnt;
    int npix;
    int bpp;
    int packets;
    bit first;
    bit run_pkt;
    bpp     = int'(eff_bpp());
    left_px = (m_total > 300) ? 300 : int'(m_total);
    first   = fresh;
    if (!m_comp) begin
      npix = (left_px == 0) ? 1 : ((left_px > 40) ? 40 : left_px);
      npix += $urandom_range(0, 1);
      repeat (npix * bpp) begin
        send_byte(pixel_byte(), first);
        first = 1'b0;
      end
      return;
    end
    packets = 0;
    do begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      if (left_px > 0 && cnt > left_px && $urandom_range(0, 7) != 0) cnt = left_px;
      run_pkt = 1'($urandom_range(0, 1));
      send_byte({run_pkt, 7'(cnt - 1)}, first);
      first = 1'b0;
      npix = run_pkt ? 1 : cnt;
      // an overrun stops the decoder, so keep the ignored tail short
      if (cnt > left_px && npix > 2) npix = 2;
      repeat (npix * bpp) send_byte(pixel_byte(), 1'b0);
      left_px -= cnt;
      packets++;
      if ($urandom_range(0, 19) == 0)
        send_byte(8'($urandom), $urandom_range(0, 29) == 0);
    end while (left_px > 0 && packets < 16);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: a run packet then a one-pixel raw packet fill the image
  task automatic test_default_image();
    send_byte(8'h8e, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    // decoder is stopped: drop this byte
    send_byte(8'h55, 1'b0);
    wait_idle();
  endtask

  // Largest packet count passes the pixel total
  task automatic test_overrun();
    send_byte(8'hff, 1'b1);
    send_byte(8'h81, 1'b0);
    wait_idle();
  endtask

  // Plain gray stream with a zero pixel total stops after one pixel
  task automatic test_zero_total_plain();
    set_config(3'd1, 1'b1, 1'b0, '0);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h5a, 1'b0);
    wait_idle();
  endtask

  // 16-bit truecolor unpack in plain mode
  task automatic test_truecolor16();
    set_config(3'd2, 1'b0, 1'b0, 31'd2);
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_idle();
  endtask

  // Unsupported formats yield zero pixels; a zero pixel size counts as one
  task automatic test_odd_formats();
    set_config(3'd3, 1'b1, 1'b1, 31'd16);
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    wait_idle();
    set_config(3'd0, 1'b0, 1'b1, 31'd16);
    send_byte(8'h01, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    wait_idle();
  endtask

  // Random settings, each followed by a few images
  task automatic test_random_images();
    int            round;
    logic [2:0]    bpp;
    logic [30:0]   total;
    int            pick;
    round = 0;
    live_bytes = 0;
    while (live_bytes < RANDOM_BYTES) begin
      bpp = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(1, 4));
      pick = $urandom_range(0, 19);
      case (pick)
        0: total = '0;
        1: total = 31'd1073741824;
        2: total = '1;
        3: total = 31'($urandom_range(100, 300));
        4: total = 31'($urandom);
        default: total = 31'($urandom_range(1, 24));
      endcase
      // walk the extremes in the first rounds
      case (round)
        0: begin bpp = 3'd7; total = '1; end
        1: begin bpp = 3'd0; total = 31'd1073741824; end
        2: total = '0;
        default: ;
      endcase
      set_config(bpp, 1'($urandom), $urandom_range(0, 3) != 0, total);
      no_idle = ($urandom_range(0, 3) == 0);
      // sometimes carry on the old image state across the setting change
      random_image($urandom_range(0, 5) != 0);
      repeat ($urandom_range(0, 2)) random_image(1'b1);
      wait_idle();
      round++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_image();
    test_overrun();
    test_zero_total_plain();
    test_truecolor16();
    test_odd_formats();
    test_random_images();
    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0 && want_pixels.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
